// ----- hdl/lowest_first_index_allocator_defines.svh -----
// assertion macros for the index allocator
`ifndef LOWEST_FIRST_INDEX_ALLOCATOR_DEFINES_SVH
`define LOWEST_FIRST_INDEX_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LFIA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, sampled on clk, off during reset
`define LFIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ----- hdl/lfia_pkg.sv -----
package lfia_pkg;

    localparam int CAP_W    = 9;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;

    // bitmap memory word
    localparam int WORD_W = 32;
    localparam int WBIT_W = 5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL          = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot_index;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_index;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ----- hdl/lowest_first_index_allocator.sv -----
// channel   | handshake             | word
// ----------+-----------------------+------------------------------
// command   | start / busy          | cmd (operation, slot_index)
// result    | done strobe           | result (granted_index, status)
// config    | cfg_valid / cfg_ready | cfg_data (capacity)
//
// each command is read and then written back: the bitmap word is read on
// acceptance into a register and written back in the next cycle.
// busy is high during the write-back; done pulses in the cycle after busy.
// rst_n clears the word valid bits, the summary and the bump pointer, so
// no sweep of the bitmap memory is needed. results cannot be stalled.
`include "lowest_first_index_allocator_defines.svh"

module lowest_first_index_allocator #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  lfia_pkg::cmd_t                   cmd,
    output logic                             done,
    output lfia_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lfia_pkg::CAP_W-1:0]       cfg_data
);

    localparam int IDX_W   = $clog2(MAX_SLOTS);
    localparam int PTR_W   = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W   = (PTR_W > lfia_pkg::CAP_W) ? PTR_W : lfia_pkg::CAP_W;
    localparam int NWORDS  = (MAX_SLOTS + lfia_pkg::WORD_W - 1) / lfia_pkg::WORD_W;
    localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int NDEPTH  = 2 ** WADDR_W;
    localparam int WORD_W  = lfia_pkg::WORD_W;
    localparam int WBIT_W  = lfia_pkg::WBIT_W;
    localparam int SLOT_W  = lfia_pkg::SLOT_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    // bitmap of freed indices: bit set means handed out before and freed since
    logic [WORD_W-1:0]  mem [NDEPTH];
    logic [WORD_W-1:0]  rdata_reg;

    logic               state_reg, state_next;
    logic [lfia_pkg::CAP_W-1:0] cap_reg;
    logic [PTR_W-1:0]   bump_reg, bump_next;
    logic [NDEPTH-1:0]  wvalid_reg, wvalid_next;
    logic [NDEPTH-1:0]  summary_reg, summary_next;

    logic               op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [WADDR_W-1:0] waddr_reg;
    logic               found_reg;
    logic               slot_ok_reg;
    logic               rvalid_reg;

    logic               done_reg, done_next;
    lfia_pkg::result_t  result_reg, result_next;

    logic               accept;
    logic               sum_any;
    logic [WADDR_W-1:0] sum_sel;
    logic [IDX_W-1:0]   slot_idx;
    logic [WADDR_W-1:0] slot_waddr;
    logic               slot_ok;
    logic [WADDR_W-1:0] raddr;

    logic [WORD_W-1:0]  word;
    logic [WBIT_W-1:0]  low_bit;
    logic [WBIT_W-1:0]  idx_bit;
    logic [WORD_W-1:0]  wdata;
    logic               mem_we;
    logic               bump_room;
    logic               is_alloc;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg == S_RUN);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    // lowest word that holds a freed index
    always_comb
    begin
        sum_any = |summary_reg;
        sum_sel = '0;
        for (int i = NDEPTH - 1; i >= 0; i--)
        begin
            if (summary_reg[i])
            begin
                sum_sel = WADDR_W'(i);
            end
        end
    end

    assign slot_idx   = IDX_W'(cmd.slot_index);
    assign slot_waddr = WADDR_W'(slot_idx >> WBIT_W);
    assign slot_ok    = CMP_W'(cmd.slot_index) < CMP_W'(MAX_SLOTS);
    assign raddr      = (cmd.operation == lfia_pkg::OP_ALLOC) ? sum_sel : slot_waddr;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= mem[raddr];
        end
        if (mem_we)
        begin
            mem[waddr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= cmd.operation;
            idx_reg     <= slot_idx;
            waddr_reg   <= raddr;
            found_reg   <= sum_any;
            slot_ok_reg <= slot_ok;
            rvalid_reg  <= wvalid_reg[raddr];
        end
        if (state_reg == S_RUN)
        begin
            result_reg <= result_next;
        end
    end

    // a word never written reads as all clear
    assign word = rvalid_reg ? rdata_reg : '0;

    always_comb
    begin
        low_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                low_bit = WBIT_W'(i);
            end
        end
    end

    assign idx_bit   = WBIT_W'(idx_reg);
    assign is_alloc  = (op_reg == lfia_pkg::OP_ALLOC);
    assign bump_room = (CMP_W'(bump_reg) < CMP_W'(cap_reg))
                       && (bump_reg < PTR_W'(MAX_SLOTS));

    always_comb
    begin
        state_next   = state_reg;
        bump_next    = bump_reg;
        wvalid_next  = wvalid_reg;
        summary_next = summary_reg;
        done_next    = 1'b0;
        result_next  = '{granted_index: '0, status: lfia_pkg::ST_OK};
        wdata        = word;
        mem_we       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (is_alloc)
                begin
                    if (found_reg)
                    begin
                        // reuse the lowest freed index
                        wdata          = word & ~(WORD_W'(1) << low_bit);
                        mem_we         = 1'b1;
                        wvalid_next[waddr_reg]  = 1'b1;
                        summary_next[waddr_reg] = |wdata;
                        result_next.granted_index =
                            SLOT_W'({waddr_reg, low_bit});
                    end
                    else if (bump_room)
                    begin
                        bump_next = bump_reg + PTR_W'(1);
                        result_next.granted_index = SLOT_W'(bump_reg);
                    end
                    else
                    begin
                        result_next.status = lfia_pkg::ST_FULL;
                    end
                end
                else
                begin
                    if (slot_ok_reg && (PTR_W'(idx_reg) < bump_reg) && !word[idx_bit])
                    begin
                        wdata          = word | (WORD_W'(1) << idx_bit);
                        mem_we         = 1'b1;
                        wvalid_next[waddr_reg]  = 1'b1;
                        summary_next[waddr_reg] = 1'b1;
                    end
                    else
                    begin
                        result_next.status = lfia_pkg::ST_NOT_ALLOCATED;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bump_reg    <= '0;
            wvalid_reg  <= '0;
            summary_reg <= '0;
            done_reg    <= 1'b0;
            cap_reg     <= lfia_pkg::CAP_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            bump_reg    <= bump_next;
            wvalid_reg  <= wvalid_next;
            summary_reg <= summary_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    `LFIA_ASSERT_NEXT(a_busy_after_start, start && !busy, busy && !done)
    `LFIA_ASSERT_NEXT(a_done_after_busy, busy, done && !busy)
    `LFIA_ASSERT_NOW(a_bump_bounded, 1'b1, bump_reg <= PTR_W'(MAX_SLOTS))
    `LFIA_ASSERT_NOW(a_fail_no_grant, done && (result.status != lfia_pkg::ST_OK), result.granted_index == '0)

endmodule

// ----- tb/tb_lowest_first_index_allocator.sv -----
`timescale 1ns / 100ps

module tb_lowest_first_index_allocator;

    localparam int MAX_SLOTS   = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       start     = 1'b0;
    logic                       busy;
    lfia_pkg::cmd_t             cmd       = '0;
    logic                       done;
    lfia_pkg::result_t          result;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [lfia_pkg::CAP_W-1:0] cfg_data  = '0;

    // predictor state
    bit                         slot_held [MAX_SLOTS];
    int                         fresh_ptr;
    int                         capacity_setting;

    lfia_pkg::cmd_t             queued_cmds[$];
    lfia_pkg::result_t          predicted_grants[$];

    int                         burst_left;
    int                         gap_left;
    bit                         draining;
    int                         failures;
    int                         cycle_count;

    lowest_first_index_allocator #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic lfia_pkg::result_t grant_or_release(lfia_pkg::cmd_t c);
        lfia_pkg::result_t r;
        int      eff_cap;
        int      lim;
        int      i;
        bit      found;
        r        = '0;
        r.status = lfia_pkg::ST_OK;
        found    = 1'b0;
        if (c.operation == lfia_pkg::OP_ALLOC)
        begin
            eff_cap = (capacity_setting > MAX_SLOTS) ? MAX_SLOTS : capacity_setting;
            lim     = (fresh_ptr < MAX_SLOTS) ? fresh_ptr : MAX_SLOTS;
            // lowest freed index wins over the bump pointer
            for (i = 0; i < lim && !found; i++)
            begin
                if (!slot_held[i])
                begin
                    found           = 1'b1;
                    slot_held[i]    = 1'b1;
                    r.granted_index = lfia_pkg::SLOT_W'(i);
                end
            end
            if (!found)
            begin
                if (fresh_ptr < eff_cap)
                begin
                    r.granted_index      = lfia_pkg::SLOT_W'(fresh_ptr);
                    slot_held[fresh_ptr] = 1'b1;
                    fresh_ptr++;
                end
                else
                begin
                    r.status = lfia_pkg::ST_FULL;
                end
            end
        end
        else
        begin
            if (int'(c.slot_index) < MAX_SLOTS && slot_held[c.slot_index])
                slot_held[c.slot_index] = 1'b0;
            else
                r.status = lfia_pkg::ST_NOT_ALLOCATED;
        end
        return r;
    endfunction

    // sender: bursts and gaps, with an occasional pause until all results are back
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        logic go;
        go = 1'b0;
        if (!rst_n)
        begin
            start      <= 1'b0;
            cmd        <= '0;
            burst_left = 0;
            gap_left   = 0;
            draining   = 1'b0;
        end
        else
        begin
            if (start && !busy)
                predicted_grants.insert(predicted_grants.size(), grant_or_release(cmd));
            if (start && busy)
            begin
                go = 1'b1;
            end
            else
            begin
                if (draining && predicted_grants.size() == 0)
                    draining = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (!draining && queued_cmds.size() > 0)
                begin
                    go = 1'b1;
                    cmd <= queued_cmds.pop_front();
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        if ($urandom_range(3) == 0)
                        begin
                            gap_left   = 0;
                            burst_left = $urandom_range(20, 120);
                        end
                        else
                        begin
                            gap_left   = $urandom_range(1, 12);
                            burst_left = $urandom_range(0, 30);
                        end
                        if ($urandom_range(7) == 0)
                            draining = 1'b1;
                    end
                end
            end
            start <= go;
        end
    end

    always @(posedge clk)
    begin
        lfia_pkg::result_t want;
        if (rst_n && done)
        begin
            if (predicted_grants.size() == 0)
            begin
                $error("result with nothing pending: granted_index %0d status %0d",
                       result.granted_index, result.status);
                failures++;
            end
            else
            begin
                want = predicted_grants.pop_front();
                if (result.granted_index !== want.granted_index)
                begin
                    $error("granted_index mismatch: expected %0d, actual %0d",
                           want.granted_index, result.granted_index);
                    failures++;
                end
                if (result.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, result.status);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_cmd(input logic op, input int slot);
        lfia_pkg::cmd_t c;
        c.operation  = op;
        c.slot_index = lfia_pkg::SLOT_W'(slot);
        queued_cmds.insert(queued_cmds.size(), c);
    endtask

    // sampled away from the active edge so the driver's updates have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_cmds.size() != 0 || start || busy || predicted_grants.size() != 0);
    endtask

    task automatic write_capacity(input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lfia_pkg::CAP_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        capacity_setting = value & ((1 << lfia_pkg::CAP_W) - 1);
    endtask

    function automatic lfia_pkg::cmd_t random_cmd(int alloc_pct, int window);
        lfia_pkg::cmd_t c;
        c.slot_index = lfia_pkg::SLOT_W'($urandom_range(0, 255));
        if ($urandom_range(99) < alloc_pct)
        begin
            c.operation = lfia_pkg::OP_ALLOC;
        end
        else
        begin
            c.operation = lfia_pkg::OP_FREE;
            // mostly frees near the live range, the rest anywhere
            if ($urandom_range(3) != 0)
                c.slot_index = lfia_pkg::SLOT_W'($urandom_range(0, window));
        end
        return c;
    endfunction

    initial
    begin
        int phase_cap   [PHASES];
        int phase_len   [PHASES];
        int phase_alloc [PHASES];
        int phase_win   [PHASES];
        int p;
        int n;
        phase_cap   = '{16, 1, 64, 0, 300, 511, 256, 2};
        phase_len   = '{150, 100, 200, 100, 250, 400, 200, 330};
        phase_alloc = '{55, 50, 60, 45, 60, 85, 45, 50};
        phase_win   = '{20, 20, 70, 70, 255, 255, 255, 255};
        for (n = 0; n < MAX_SLOTS; n++)
            slot_held[n] = 1'b0;
        fresh_ptr        = 0;
        capacity_setting = lfia_pkg::CAP_RESET;
        failures         = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_capacity(4);
        add_cmd(lfia_pkg::OP_FREE, 0);       // never handed out
        add_cmd(lfia_pkg::OP_FREE, 255);
        add_cmd(lfia_pkg::OP_ALLOC, 255);
        add_cmd(lfia_pkg::OP_ALLOC, 0);
        add_cmd(lfia_pkg::OP_ALLOC, 0);
        add_cmd(lfia_pkg::OP_ALLOC, 0);
        add_cmd(lfia_pkg::OP_ALLOC, 0);      // full
        add_cmd(lfia_pkg::OP_FREE, 2);
        add_cmd(lfia_pkg::OP_FREE, 2);       // double free
        add_cmd(lfia_pkg::OP_FREE, 0);
        add_cmd(lfia_pkg::OP_ALLOC, 0);
        add_cmd(lfia_pkg::OP_ALLOC, 0);
        add_cmd(lfia_pkg::OP_ALLOC, 0);
        wait_drained();

        // capacity below the bump pointer: only reuse
        write_capacity(2);
        add_cmd(lfia_pkg::OP_FREE, 3);
        add_cmd(lfia_pkg::OP_ALLOC, 0);
        add_cmd(lfia_pkg::OP_ALLOC, 0);
        wait_drained();

        write_capacity(0);
        add_cmd(lfia_pkg::OP_FREE, 1);
        add_cmd(lfia_pkg::OP_ALLOC, 0);
        add_cmd(lfia_pkg::OP_ALLOC, 0);
        wait_drained();

        // above the slot count, clipped
        write_capacity(511);
        add_cmd(lfia_pkg::OP_ALLOC, 0);
        add_cmd(lfia_pkg::OP_FREE, 4);
        wait_drained();

        for (p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_cap[p]);
            for (n = 0; n < phase_len[p]; n++)
                queued_cmds.insert(queued_cmds.size(),
                                   random_cmd(phase_alloc[p], phase_win[p]));
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- lowest_first_index_allocator.f -----
+incdir+hdl
hdl/lfia_pkg.sv
hdl/lowest_first_index_allocator.sv
tb/tb_lowest_first_index_allocator.sv
